FILE: hw/rtl/djq_pkg.sv
// Shared types and codes for the dual job queue with cancel.
package djq_pkg;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CANCEL = 3'd2,
    OP_FIND   = 3'd3,
    OP_EXIST  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_t;

  // One stored job.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
    logic [7:0]  kind;
  } entry_t;

  // Input item.
  typedef struct packed {
    logic [2:0]  op;
    logic        queue_sel;
    logic [15:0] job_id;
    logic [15:0] page_count;
    logic [7:0]  job_kind;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] out_id;
    logic [15:0] out_pages;
    logic [7:0]  out_kind;
    logic [4:0]  queue_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: hw/rtl/dual_job_queue_with_cancel.sv
// Top level of the dual job queue with cancel.
// Two job queues (normal and priority) of QUEUE_DEPTH entries each, holding
// a job id, page count and kind byte. One item is handled at a time and
// gives one result item: the item is captured together with the id match
// lines of both queues in the idle state, the operation executes in the
// execute state, and the result is offered from the result register in
// the respond state; a new item is taken only once the result has been
// accepted. Cancel closes up later entries.
module dual_job_queue_with_cancel #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  djq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output djq_pkg::out_t out_data
);
  import djq_pkg::*;

  cmd_t cmd;

  djq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  djq_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/djq_ctrl.sv
// Controller state machine that sequences one item through load, execute and respond.
module djq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output djq_pkg::cmd_t cmd
);
  import djq_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // An execute step always follows a load.
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.load)) else $error("execute without load");

  // A load is always followed by an execute.
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("load not followed by execute");

  // Input and output are never open at once.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid overlap");

endmodule

FILE: hw/rtl/djq_dpath.sv
// Datapath: the two queue stores, counts, id match lines and the result register.
module djq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  djq_pkg::cmd_t cmd,
  input  djq_pkg::in_t  in_data,
  output djq_pkg::out_t out_data
);
  import djq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t                 ent_r   [2][QUEUE_DEPTH];
  logic [CW-1:0]          cnt_r   [2];
  logic [QUEUE_DEPTH-1:0] match_r [2];
  in_t                    req_r;
  out_t                   res_r;

  logic          q;
  logic [CW-1:0] cur;
  logic [CW-1:0] cnt_nxt;
  logic [IW-1:0] pos;
  logic [IW-1:0] drop_pos;
  logic          drop;
  logic          do_write;
  logic          hit;
  logic          any_hit;
  out_t          res_nxt;
  entry_t        sel;

  assign q   = req_r.queue_sel;
  assign cur = cnt_r[q];
  assign hit = |match_r[q];
  assign any_hit = (|match_r[0]) | (|match_r[1]);

  // First matching slot nearest the head.
  always_comb begin
    pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match_r[q][i]) pos = IW'(i);
    end
  end

  // Operation decode and result.
  always_comb begin
    res_nxt  = '0;
    cnt_nxt  = cur;
    drop     = 1'b0;
    drop_pos = '0;
    do_write = 1'b0;
    sel      = ent_r[q][pos];
    case (op_t'(req_r.op))
      OP_APPEND: begin
        if (cur == CW'(QUEUE_DEPTH)) begin
          res_nxt.status = ST_FULL;
        end else begin
          do_write = 1'b1;
          cnt_nxt  = cur + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cur == '0) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.found     = 1'b1;
          res_nxt.out_id    = ent_r[q][0].id;
          res_nxt.out_pages = ent_r[q][0].pages;
          res_nxt.out_kind  = ent_r[q][0].kind;
          drop    = 1'b1;
          cnt_nxt = cur - 1'b1;
        end
      end
      OP_CANCEL, OP_FIND: begin
        if (!hit) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.found     = 1'b1;
          res_nxt.out_id    = sel.id;
          res_nxt.out_pages = sel.pages;
          res_nxt.out_kind  = sel.kind;
          if (op_t'(req_r.op) == OP_CANCEL) begin
            drop     = 1'b1;
            drop_pos = pos;
            cnt_nxt  = cur - 1'b1;
          end
        end
      end
      OP_EXIST: begin
        if (any_hit) res_nxt.found = 1'b1;
        else res_nxt.status = ST_EMPTY;
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cur;
      end
    endcase
    res_nxt.queue_count = 5'(cnt_nxt);
  end

  // Counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else if (cmd.exec) begin
      cnt_r[q] <= cnt_nxt;
    end
  end

  // Request capture, match lines, entry store and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          match_r[k][i] <= (ent_r[k][i].id == in_data.job_id) && (CW'(i) < cnt_r[k]);
        end
      end
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      if (do_write) begin
        ent_r[q][cur[IW-1:0]] <= '{id: req_r.job_id, pages: req_r.page_count,
                                   kind: req_r.job_kind};
      end
      if (drop) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (IW'(i) >= drop_pos) ent_r[q][i] <= ent_r[q][i + 1];
        end
      end
    end
  end

  assign out_data = res_r;

  // Counts never exceed the queue depth.
  a_cnt0: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(QUEUE_DEPTH)) else $error("normal count overflow");
  a_cnt1: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[1] <= CW'(QUEUE_DEPTH)) else $error("priority count overflow");
  // A found lookup in the selected queue implies a match line was set.
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op_t'(req_r.op) == OP_FIND) && res_nxt.found) |-> hit)
    else $error("find without match");

endmodule
